// ----- src/sobel_pkg.sv -----
// Shared types, constants and helpers for the Sobel edge magnitude block.
// Used by every module under src; depends on nothing else.
`default_nettype none

package sobel_pkg;

   // Geometry limits of the supported frames.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 13;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [SIZE_W-1:0] SIZE_MIN     = 13'd3;

   // Arithmetic widths of the gradient and root path.
   localparam int GRAD_W      = 11;
   localparam int ENERGY_W    = 21;
   localparam int RADICAND_W  = 16;
   localparam int SQRT_STEPS  = RADICAND_W / 2;
   localparam int REM_W       = 10;
   localparam logic [7:0] EDGE_MAX = 8'd255;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0]       edge_value;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_last;
   } edge_item_type;

   // Gradients of one interior pixel, handed from front to back.
   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic [ROW_W-1:0]         out_row;
      logic [COL_W-1:0]         out_col;
      logic                     frame_last;
   } grad_item_type;

   // One stage of the digit-by-digit square root.
   typedef struct packed {
      logic                  sat;
      logic [RADICAND_W-1:0] radicand;
      logic [REM_W-1:0]      rem;
      logic [7:0]            root;
      logic [ROW_W-1:0]      out_row;
      logic [COL_W-1:0]      out_col;
      logic                  frame_last;
   } sqrt_stage_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_WORK
   } front_state_type;

   // Clamp a written frame dimension into the supported range.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v < SIZE_MIN) begin
         r = SIZE_MIN;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/sobel_edge_magnitude.sv -----
// Sobel 3x3 edge magnitude, top level: configuration registers and the
// front end, queue and back end. Depends on sobel_pkg and all src modules.
//
// Pixels enter in raster order on the req channel, and a new pixel is not
// taken until the last is done: each pixel reads its column of the line
// store when accepted and writes it back when its work completes, and that
// read-then-write sets the rate. Every interior pixel gives one result on
// the rsp channel with the row and column of its window centre, one less
// than its own, and a last-of-frame mark; border pixels give none. On its
// way a result passes the front end's item registers, the queue into the
// gradient energy register, the root, taken one bit per pipeline stage,
// and the output register. A queue of four items lets the front end keep
// taking pixels while the output is stalled. The line store is not cleared
// after reset; it needs no clearing pass, as stale contents reach only
// border pixels, which give no result. Frame width and height are written
// at csr indexes 0 and 1, clamped to 3..4096, and should only change while
// the block is idle.
`default_nettype none

module sobel_edge_magnitude (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire sobel_pkg::pixel_item_type         req_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output sobel_pkg::edge_item_type               rsp_item,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sobel_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sobel_pkg::SIZE_W-1:0]      csr_wdata
);

   logic [sobel_pkg::SIZE_W-1:0] width_ff, height_ff;

   logic                     push_valid, push_ready;
   sobel_pkg::grad_item_type push_item;
   logic                     pop_valid, pop_ready;
   sobel_pkg::grad_item_type pop_item;

   assign csr_ready = 1'b1;

   // Frame size registers, stored already clamped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sobel_pkg::WIDTH_RESET;
         height_ff <= sobel_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sobel_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= sobel_pkg::clamp_size(csr_wdata,
                                                 sobel_pkg::SIZE_W'(sobel_pkg::MAX_WIDTH));
            end
            sobel_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= sobel_pkg::clamp_size(csr_wdata,
                                                  sobel_pkg::SIZE_W'(sobel_pkg::MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   sobel_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .image_width  (width_ff),
      .image_height (height_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_item    (push_item)
   );

   sobel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sobel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ----- src/sobel_front.sv -----
// Front end: pixel position tracking, the two line stores and the window,
// and the Sobel gradients of interior pixels. Depends on sobel_pkg.
`default_nettype none

module sobel_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire sobel_pkg::pixel_item_type     req_item,
   input  wire logic [sobel_pkg::SIZE_W-1:0]  image_width,
   input  wire logic [sobel_pkg::SIZE_W-1:0]  image_height,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output sobel_pkg::grad_item_type           push_item
);

   sobel_pkg::front_state_type state_ff, state_in;

   logic accept;
   logic work_done;

   // Position counters of the next pixel.
   logic [sobel_pkg::COL_W-1:0] col_count_ff;
   logic [sobel_pkg::ROW_W-1:0] row_count_ff;

   // Position and data of the item in progress.
   logic [sobel_pkg::COL_W-1:0] pos_c_ff;
   logic [sobel_pkg::ROW_W-1:0] pos_r_ff;
   logic [7:0]                  pix_ff;
   logic                        interior_ff;
   logic                        last_ff;

   // Both line stores share one address, so they sit side by side in one
   // memory word: upper row in the high byte, middle row in the low byte.
   logic [15:0] line_mem [sobel_pkg::MAX_WIDTH];
   logic [15:0] rd_ff;

   // The two most recent window columns; column 0 is the older one.
   logic [7:0] win_ff [3][2];

   logic [sobel_pkg::COL_W-1:0]  col_start, pos_c, col_nx;
   logic [sobel_pkg::ROW_W-1:0]  row_start, pos_r, row_nx;
   logic [sobel_pkg::SIZE_W-1:0] row_step, col_next_wide, row_next_wide;
   logic                         interior, last;

   logic [7:0]  top_pix, mid_pix;
   logic [9:0]  sum_right, sum_left, sum_up, sum_down;

   // Handshake and state sequencing.
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      work_done = 1'b0;
      case (state_ff)
         sobel_pkg::FRONT_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = sobel_pkg::FRONT_WORK;
            end
         end
         sobel_pkg::FRONT_WORK: begin
            if (!interior_ff || push_ready) begin
               work_done = 1'b1;
               state_in  = sobel_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = sobel_pkg::FRONT_IDLE;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sobel_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Position of the arriving pixel, with wrap on a shrunk size, and the
   // position that follows it.
   always_comb begin
      col_start = req_item.frame_start ? '0 : col_count_ff;
      row_start = req_item.frame_start ? '0 : row_count_ff;
      if (sobel_pkg::SIZE_W'(col_start) >= image_width) begin
         pos_c    = '0;
         row_step = sobel_pkg::SIZE_W'(row_start) + sobel_pkg::SIZE_W'(1);
      end else begin
         pos_c    = col_start;
         row_step = sobel_pkg::SIZE_W'(row_start);
      end
      pos_r = (row_step >= image_height) ? '0 : row_step[sobel_pkg::ROW_W-1:0];

      col_next_wide = sobel_pkg::SIZE_W'(pos_c) + sobel_pkg::SIZE_W'(1);
      row_next_wide = sobel_pkg::SIZE_W'(pos_r) + sobel_pkg::SIZE_W'(1);
      if (col_next_wide >= image_width) begin
         col_nx = '0;
         row_nx = (row_next_wide >= image_height) ? '0
                                                  : row_next_wide[sobel_pkg::ROW_W-1:0];
      end else begin
         col_nx = col_next_wide[sobel_pkg::COL_W-1:0];
         row_nx = pos_r;
      end

      interior = (pos_r >= sobel_pkg::ROW_W'(2)) && (pos_c >= sobel_pkg::COL_W'(2));
      last     = (sobel_pkg::SIZE_W'(pos_r) == image_height - sobel_pkg::SIZE_W'(1)) &&
                 (sobel_pkg::SIZE_W'(pos_c) == image_width - sobel_pkg::SIZE_W'(1));
   end

   // Counters move on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_nx;
         row_count_ff <= row_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_c_ff    <= pos_c;
         pos_r_ff    <= pos_r;
         pix_ff      <= req_item.pixel_value;
         interior_ff <= interior;
         last_ff     <= last;
      end
   end

   // Line store: read on acceptance, written back when the item completes.
   // The two never fall in the same cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[pos_c];
      end
      if (work_done) begin
         line_mem[pos_c_ff] <= {rd_ff[7:0], pix_ff};
      end
   end

   assign top_pix = rd_ff[15:8];
   assign mid_pix = rd_ff[7:0];

   // Window shift when the item completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= '0;
            win_ff[k][1] <= '0;
         end
      end else if (work_done) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
         end
         win_ff[0][1] <= top_pix;
         win_ff[1][1] <= mid_pix;
         win_ff[2][1] <= pix_ff;
      end
   end

   // Sobel gradients over the two stored window columns and the new column.
   always_comb begin
      sum_right = 10'(top_pix) + 10'({mid_pix, 1'b0}) + 10'(pix_ff);
      sum_left  = 10'(win_ff[0][0]) + 10'({win_ff[1][0], 1'b0}) + 10'(win_ff[2][0]);
      sum_up    = 10'(win_ff[0][0]) + 10'({win_ff[0][1], 1'b0}) + 10'(top_pix);
      sum_down  = 10'(win_ff[2][0]) + 10'({win_ff[2][1], 1'b0}) + 10'(pix_ff);
      push_item.gx = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      push_item.gy = $signed({1'b0, sum_up}) - $signed({1'b0, sum_down});
      push_item.out_row    = pos_r_ff - sobel_pkg::ROW_W'(1);
      push_item.out_col    = pos_c_ff - sobel_pkg::COL_W'(1);
      push_item.frame_last = last_ff;
   end

   assign push_valid = (state_ff == sobel_pkg::FRONT_WORK) && interior_ff;

   // An accepted item is always worked on in the following cycle.
   a_accept_to_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sobel_pkg::FRONT_WORK)
      else $error("front did not enter work after acceptance");

   // Only interior pixels reach the back end.
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_item.out_row != '0) && (push_item.out_col != '0))
      else $error("border pixel pushed to back end");

endmodule

`default_nettype wire

// ----- src/sobel_queue.sv -----
// Short queue of gradient items between the front and back ends.
// Depends on sobel_pkg.
`default_nettype none

module sobel_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   output logic                           push_ready,
   input  wire sobel_pkg::grad_item_type  push_item,
   output logic                           pop_valid,
   input  wire logic                      pop_ready,
   output sobel_pkg::grad_item_type       pop_item
);

   sobel_pkg::grad_item_type entry_ff [sobel_pkg::QUEUE_DEPTH];

   logic [sobel_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [sobel_pkg::QUEUE_PTR_W:0]   count_ff;
   logic                              do_push, do_pop;

   assign push_ready = count_ff != (sobel_pkg::QUEUE_PTR_W+1)'(sobel_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + sobel_pkg::QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + sobel_pkg::QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (sobel_pkg::QUEUE_PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (sobel_pkg::QUEUE_PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The fill count always matches the pointer distance.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[sobel_pkg::QUEUE_PTR_W-1:0])
      else $error("queue fill count out of step with pointers");

endmodule

`default_nettype wire

// ----- src/sobel_back.sv -----
// Back end: gradient energy, pipelined integer square root with saturation,
// and the result output register. Depends on sobel_pkg.
`default_nettype none

module sobel_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire sobel_pkg::grad_item_type  pop_item,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output sobel_pkg::edge_item_type       rsp_item
);

   logic advance;

   logic [sobel_pkg::SQRT_STEPS:0]  stage_valid_ff;
   sobel_pkg::sqrt_stage_type       stage_ff [sobel_pkg::SQRT_STEPS+1];
   sobel_pkg::sqrt_stage_type       stage_in [sobel_pkg::SQRT_STEPS+1];

   logic                            rsp_valid_ff;
   sobel_pkg::edge_item_type        rsp_item_ff;

   logic signed [2*sobel_pkg::GRAD_W-1:0] sq_x, sq_y;
   logic [sobel_pkg::ENERGY_W-1:0]        energy;
   logic [sobel_pkg::REM_W+1:0]           rem_sh [sobel_pkg::SQRT_STEPS];
   logic [sobel_pkg::REM_W+1:0]           trial  [sobel_pkg::SQRT_STEPS];

   // The whole pipeline moves when the output register is free or taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = advance;

   // Energy of the queue head and one root digit per stage.
   always_comb begin
      sq_x   = pop_item.gx * pop_item.gx;
      sq_y   = pop_item.gy * pop_item.gy;
      energy = sobel_pkg::ENERGY_W'(sq_x) + sobel_pkg::ENERGY_W'(sq_y);

      stage_in[0].sat        = energy[sobel_pkg::ENERGY_W-1:sobel_pkg::RADICAND_W] != '0;
      stage_in[0].radicand   = energy[sobel_pkg::RADICAND_W-1:0];
      stage_in[0].rem        = '0;
      stage_in[0].root       = '0;
      stage_in[0].out_row    = pop_item.out_row;
      stage_in[0].out_col    = pop_item.out_col;
      stage_in[0].frame_last = pop_item.frame_last;

      for (int j = 0; j < sobel_pkg::SQRT_STEPS; j++) begin
         stage_in[j+1] = stage_ff[j];
         rem_sh[j] = {stage_ff[j].rem,
                      stage_ff[j].radicand[sobel_pkg::RADICAND_W-1-2*j -: 2]};
         trial[j]  = (sobel_pkg::REM_W+2)'({stage_ff[j].root, 2'b01});
         if (rem_sh[j] >= trial[j]) begin
            stage_in[j+1].rem  = sobel_pkg::REM_W'(rem_sh[j] - trial[j]);
            stage_in[j+1].root = {stage_ff[j].root[6:0], 1'b1};
         end else begin
            stage_in[j+1].rem  = sobel_pkg::REM_W'(rem_sh[j]);
            stage_in[j+1].root = {stage_ff[j].root[6:0], 1'b0};
         end
      end
   end

   // Stage valids and the output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[sobel_pkg::SQRT_STEPS-1:0], pop_valid};
         rsp_valid_ff   <= stage_valid_ff[sobel_pkg::SQRT_STEPS];
      end
   end

   // Stage payloads and the result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= sobel_pkg::SQRT_STEPS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         rsp_item_ff.edge_value <= stage_ff[sobel_pkg::SQRT_STEPS].sat
                                   ? sobel_pkg::EDGE_MAX
                                   : stage_ff[sobel_pkg::SQRT_STEPS].root;
         rsp_item_ff.out_row    <= stage_ff[sobel_pkg::SQRT_STEPS].out_row;
         rsp_item_ff.out_col    <= stage_ff[sobel_pkg::SQRT_STEPS].out_col;
         rsp_item_ff.frame_last <= stage_ff[sobel_pkg::SQRT_STEPS].frame_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The last stage holds the floor square root of its radicand.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[sobel_pkg::SQRT_STEPS] && !stage_ff[sobel_pkg::SQRT_STEPS].sat |->
      (17'(stage_ff[sobel_pkg::SQRT_STEPS].root) * 17'(stage_ff[sobel_pkg::SQRT_STEPS].root)
         <= 17'(stage_ff[sobel_pkg::SQRT_STEPS].radicand)) &&
      ((17'(stage_ff[sobel_pkg::SQRT_STEPS].root) + 17'd1) *
       (17'(stage_ff[sobel_pkg::SQRT_STEPS].root) + 17'd1)
         > 17'(stage_ff[sobel_pkg::SQRT_STEPS].radicand)))
      else $error("square root stage result is not the floor root");

endmodule

`default_nettype wire
